FILE: rtl/fhss_slot_tx_gate_defines.svh
// assertion macros shared by the slot transmit gate rtl
// depends on nothing; included by files that carry checks
`ifndef FHSS_SLOT_TX_GATE_DEFINES_SVH
`define FHSS_SLOT_TX_GATE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slot tx gate check failed");

// next-cycle implication, disabled in reset
`define FST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slot tx gate check failed");

`endif

FILE: rtl/fst_pkg.sv
// shared types, codes and constants of the slot transmit gate
// no dependencies
`default_nettype none

package fst_pkg;

	// default widths
	localparam int SLOT_BITS_DEF = 64;
	localparam int TIME_BITS_DEF = 16;

	// stream widths
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 72;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXP_GEN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_LEN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POST_GUARD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_GUARD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_QUIET_TRIG = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_QUIET_LEN  = 3'd7;

	// register reset values
	localparam logic [31:0] RST_EXP_GEN    = 32'd0;
	localparam logic [15:0] RST_SLOT_LEN   = 16'd300;
	localparam logic [9:0]  RST_MIN_GAP    = 10'd150;
	localparam logic [7:0]  RST_POST_GUARD = 8'd25;
	localparam logic [7:0]  RST_TAIL_GUARD = 8'd40;
	localparam logic [11:0] RST_TIMEOUT    = 12'd1200;
	localparam logic [3:0]  RST_QUIET_TRIG = 4'd8;
	localparam logic [13:0] RST_QUIET_LEN  = 14'd4000;

	// saturation limits
	localparam logic [11:0] GATE_AGE_MAX = 12'hfff;
	localparam logic [3:0]  UNANS_MAX    = 4'hf;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_REQ  = 2'd1,
		CMD_DONE = 2'd2,
		CMD_RX   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		VD_NONE     = 2'd0,
		VD_GRANT    = 2'd1,
		VD_UNUSABLE = 2'd2,
		VD_TIMEOUT  = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [31:0] expected_generation;
		logic [15:0] slot_length_ms;
		logic [9:0]  min_gap_ms;
		logic [7:0]  post_guard_ms;
		logic [7:0]  tail_guard_ms;
		logic [11:0] gate_timeout_ms;
		logic [3:0]  quiet_trigger;
		logic [13:0] quiet_length_ms;
	} cfg_t;

	typedef struct packed {
		cmd_t        cmd;
		logic        hop_enabled;
		logic        hop_synced;
		logic        role_is_master;
		logic [31:0] status_generation;
		logic        error_present;
		logic [63:0] current_slot;
		logic        send_ok;
	} item_t;

	typedef struct packed {
		verdict_t    verdict;
		logic        request_busy;
		logic        quiet_active;
		logic        window_open;
		logic [63:0] window_slot_out;
		logic        window_reused;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/fst_cfg.sv
// configuration register file of the slot transmit gate
// depends on fst_pkg
`default_nettype none

module fst_cfg
	import fst_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_generation <= RST_EXP_GEN;
			cfg_q.slot_length_ms      <= RST_SLOT_LEN;
			cfg_q.min_gap_ms          <= RST_MIN_GAP;
			cfg_q.post_guard_ms       <= RST_POST_GUARD;
			cfg_q.tail_guard_ms       <= RST_TAIL_GUARD;
			cfg_q.gate_timeout_ms     <= RST_TIMEOUT;
			cfg_q.quiet_trigger       <= RST_QUIET_TRIG;
			cfg_q.quiet_length_ms     <= RST_QUIET_LEN;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_EXP_GEN:    cfg_q.expected_generation <= wr_data;
				REG_SLOT_LEN:   cfg_q.slot_length_ms      <= wr_data[15:0];
				REG_MIN_GAP:    cfg_q.min_gap_ms          <= wr_data[9:0];
				REG_POST_GUARD: cfg_q.post_guard_ms       <= wr_data[7:0];
				REG_TAIL_GUARD: cfg_q.tail_guard_ms       <= wr_data[7:0];
				REG_TIMEOUT:    cfg_q.gate_timeout_ms     <= wr_data[11:0];
				REG_QUIET_TRIG: cfg_q.quiet_trigger       <= wr_data[3:0];
				REG_QUIET_LEN:  cfg_q.quiet_length_ms     <= wr_data[13:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/fst_core.sv
// gate state machine and result register of the slot transmit gate
// depends on fst_pkg and fhss_slot_tx_gate_defines.svh
`default_nettype none
`include "fhss_slot_tx_gate_defines.svh"

module fst_core
	import fst_pkg::*;
#(
	parameter int SLOT_BITS = SLOT_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output res_t       res
);

	localparam int RW = ((TIME_BITS > 16) ? TIME_BITS : 16) + 2;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_QUIET = 3'd1,
		PH_GAP   = 3'd2,
		PH_WAIT  = 3'd3,
		PH_GUARD = 3'd4
	} phase_t;

	phase_t                phase_q, n_phase;
	logic [3:0]            unans_q, n_unans;
	logic                  ever_q, n_ever;
	logic [TIME_BITS-1:0]  since_q, n_since;
	logic                  wv_q, n_wv;
	logic [SLOT_BITS-1:0]  held_q, n_held;
	logic [TIME_BITS-1:0]  age_q, n_age;
	logic [SLOT_BITS-1:0]  base_q, n_base;
	logic [SLOT_BITS-1:0]  cand_q, n_cand;
	logic [13:0]           timer_q, n_timer;
	logic [11:0]           gate_q, n_gate;
	res_t                  res_s2;

	logic                  usable;
	logic [SLOT_BITS-1:0]  slot;
	logic [13:0]           t_dec;
	logic                  do_gap;
	logic                  granted;
	logic                  reused;
	verdict_t              verdict;
	logic signed [RW-1:0]  used;
	logic signed [RW-1:0]  room;

	// status check and slot masking
	assign usable = item.hop_enabled && item.hop_synced && item.role_is_master &&
		(item.status_generation == cfg.expected_generation) && !item.error_present;
	assign slot = item.current_slot[SLOT_BITS-1:0];

	// next state of the gate for the item in the input register
	always_comb begin
		n_phase = phase_q;
		n_unans = unans_q;
		n_ever  = ever_q;
		n_since = since_q;
		n_wv    = wv_q;
		n_held  = held_q;
		n_age   = age_q;
		n_base  = base_q;
		n_cand  = cand_q;
		n_timer = timer_q;
		n_gate  = gate_q;
		verdict = VD_NONE;
		reused  = 1'b0;
		granted = 1'b0;
		do_gap  = 1'b0;
		t_dec   = (timer_q != 14'd0) ? timer_q - 14'd1 : timer_q;
		used    = '0;
		room    = '0;

		case (item.cmd)
			CMD_TICK: begin
				if (since_q != '1)
					n_since = since_q + 1'b1;
				if (wv_q && (age_q != '1))
					n_age = age_q + 1'b1;
				unique case (phase_q)
					PH_QUIET: begin
						n_timer = t_dec;
						if (t_dec == 14'd0) begin
							n_unans = 4'd0;
							do_gap  = 1'b1;
						end
					end
					PH_GAP: do_gap = 1'b1;
					PH_WAIT: begin
						if (gate_q >= cfg.gate_timeout_ms) begin
							n_phase = PH_IDLE;
							verdict = VD_TIMEOUT;
						end else begin
							if (gate_q != GATE_AGE_MAX)
								n_gate = gate_q + 12'd1;
							if (!usable) begin
								n_phase = PH_IDLE;
								verdict = VD_UNUSABLE;
							end else if (slot != base_q) begin
								n_cand = slot;
								if (cfg.post_guard_ms == 8'd0) begin
									n_wv    = 1'b1;
									n_held  = slot;
									n_age   = '0;
									n_phase = PH_IDLE;
									verdict = VD_GRANT;
								end else begin
									n_phase = PH_GUARD;
									n_timer = 14'(cfg.post_guard_ms);
								end
							end
						end
					end
					PH_GUARD: begin
						if (gate_q != GATE_AGE_MAX)
							n_gate = gate_q + 12'd1;
						n_timer = t_dec;
						if (t_dec == 14'd0) begin
							if (usable && (slot == cand_q)) begin
								n_wv    = 1'b1;
								n_held  = cand_q;
								n_age   = '0;
								n_phase = PH_IDLE;
								verdict = VD_GRANT;
							end else begin
								n_phase = PH_WAIT;
							end
						end
					end
					default: ;
				endcase
			end
			CMD_REQ: begin
				if (phase_q == PH_IDLE) begin
					if (unans_q >= cfg.quiet_trigger) begin
						n_wv = 1'b0;
						if (cfg.quiet_length_ms == 14'd0) begin
							n_unans = 4'd0;
							do_gap  = 1'b1;
						end else begin
							n_phase = PH_QUIET;
							n_timer = cfg.quiet_length_ms;
						end
					end else begin
						do_gap = 1'b1;
					end
				end
			end
			CMD_DONE: begin
				if (item.send_ok) begin
					n_ever  = 1'b1;
					n_since = '0;
					if (unans_q != UNANS_MAX)
						n_unans = unans_q + 4'd1;
				end else begin
					n_wv = 1'b0;
				end
			end
			default: n_unans = 4'd0;
		endcase

		// gap check, then reuse of the held window, then start of the wait or an unusable verdict
		if (do_gap) begin
			if (ever_q && (n_since < TIME_BITS'(cfg.min_gap_ms))) begin
				n_phase = PH_GAP;
			end else begin
				used = $signed(RW'(n_age)) + $signed(RW'(cfg.tail_guard_ms));
				room = $signed(RW'(cfg.slot_length_ms)) - $signed(RW'(cfg.post_guard_ms));
				if (n_wv) begin
					if (usable && (slot == n_held) && (used < room)) begin
						n_phase = PH_IDLE;
						reused  = 1'b1;
						granted = 1'b1;
						verdict = VD_GRANT;
					end else begin
						n_wv = 1'b0;
					end
				end
				if (!granted) begin
					if (!usable) begin
						n_phase = PH_IDLE;
						verdict = VD_UNUSABLE;
					end else begin
						n_base  = slot;
						n_gate  = 12'd0;
						n_phase = PH_WAIT;
					end
				end
			end
		end
	end

	// gate state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			unans_q <= 4'd0;
			ever_q  <= 1'b0;
			since_q <= '0;
			wv_q    <= 1'b0;
			held_q  <= '0;
			age_q   <= '0;
			base_q  <= '0;
			cand_q  <= '0;
			timer_q <= 14'd0;
			gate_q  <= 12'd0;
			res_s2  <= '0;
		end else if (adv) begin
			phase_q <= n_phase;
			unans_q <= n_unans;
			ever_q  <= n_ever;
			since_q <= n_since;
			wv_q    <= n_wv;
			held_q  <= n_held;
			age_q   <= n_age;
			base_q  <= n_base;
			cand_q  <= n_cand;
			timer_q <= n_timer;
			gate_q  <= n_gate;
			res_s2.verdict         <= verdict;
			res_s2.request_busy    <= (n_phase != PH_IDLE);
			res_s2.quiet_active    <= (n_phase == PH_QUIET);
			res_s2.window_open     <= n_wv;
			res_s2.window_slot_out <= n_wv ? 64'(n_held) : 64'd0;
			res_s2.window_reused   <= (verdict == VD_GRANT) && reused;
		end
	end

	assign res = res_s2;

	// checks on gate state and result consistency
	`FST_ASSERT_NOW(a_quiet_no_window, clk, arst_n, phase_q == PH_QUIET, !wv_q)
	`FST_ASSERT_NOW(a_guard_timer_live, clk, arst_n, phase_q == PH_GUARD, timer_q != 14'd0)
	`FST_ASSERT_NOW(a_grant_holds_window, clk, arst_n, res_s2.verdict == VD_GRANT,
		res_s2.window_open && !res_s2.request_busy)
	`FST_ASSERT_NOW(a_reuse_is_grant, clk, arst_n, res_s2.window_reused,
		res_s2.verdict == VD_GRANT)

endmodule

`default_nettype wire

FILE: rtl/fhss_slot_tx_gate.sv
// Path: an accepted item is held in the input register, its result in the result register.
// Throughput: one item per cycle; input register and result register let a new item enter
// while the previous result waits, so the rate is set only by the sink taking results.
// Reset: arst_n clears the gate state, both valid flags and restores register defaults.
// top level of the slot transmit gate; depends on fst_pkg, fst_cfg, fst_core, fhss_slot_tx_gate_defines.svh
`default_nettype none
`include "fhss_slot_tx_gate_defines.svh"

module fhss_slot_tx_gate
	import fst_pkg::*;
#(
	parameter int SLOT_BITS = SLOT_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input items
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// hop_enabled, hop_synced, role_is_master, status_generation[31:0], error_present,
	// current_slot[63:0], send_ok, zero fill
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// cmd[1:0]
	input  wire logic [1:0]            s_tuser,
	// result items
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// verdict[1:0], request_busy, quiet_active, window_open, window_slot_out[63:0],
	// window_reused, zero fill
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic  s1_valid_q;
	logic  m_valid_q;
	item_t item_s1;
	logic  adv;
	logic  in_acc;
	cfg_t  cfg;
	res_t  res;

	// handshake: the item in the input register moves on when the result slot frees
	assign adv      = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || adv;
	assign in_acc   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// input register valid and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (in_acc)
				s1_valid_q <= 1'b1;
			else if (adv)
				s1_valid_q <= 1'b0;
			if (adv)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.cmd               <= cmd_t'(s_tuser);
			item_s1.hop_enabled       <= s_tdata[0];
			item_s1.hop_synced        <= s_tdata[1];
			item_s1.role_is_master    <= s_tdata[2];
			item_s1.status_generation <= s_tdata[34:3];
			item_s1.error_present     <= s_tdata[35];
			item_s1.current_slot      <= s_tdata[99:36];
			item_s1.send_ok           <= s_tdata[100];
		end
	end

	fst_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	fst_core #(
		.SLOT_BITS (SLOT_BITS),
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result packing
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, res.window_reused, res.window_slot_out, res.window_open,
		res.quiet_active, res.request_busy, res.verdict};

	// checks on the register handoff
	`FST_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_acc, s1_valid_q)
	`FST_ASSERT_NEXT(a_adv_fills_out, clk, arst_n, adv, m_valid_q)
	`FST_ASSERT_NOW(a_stall_blocks_adv, clk, arst_n, m_valid_q && !m_tready, !adv)

endmodule

`default_nettype wire

FILE: tb/sv/fst_gate_checker.sv
// scoreboard for the slot transmit gate: watches the item, result and register channels,
// predicts every result from its own copy of the gate state and compares field by field
// depends on fst_pkg
`timescale 1ns / 100ps

module fst_gate_checker
	import fst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           fail_count,
	output int unsigned           in_flight
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_QUIET,
		PH_GAP,
		PH_WAIT,
		PH_GUARD
	} gate_phase_t;

	// shadow copy of the registers and the gate state
	cfg_t        regs;
	gate_phase_t ph;
	logic [3:0]  unanswered;
	logic        sent_once;
	logic [15:0] since_send;
	logic [15:0] win_age;
	logic        win_valid;
	logic [63:0] win_slot;
	logic [63:0] base_slot;
	logic [63:0] cand_slot;
	logic [13:0] phase_timer;
	logic [11:0] gate_age;
	logic        reused_flag;

	res_t pending_results[$];
	res_t oldest;
	res_t seen;

	function verdict_t open_new_window();
		win_valid = 1'b1;
		win_slot = cand_slot;
		win_age = '0;
		ph = PH_IDLE;
		return VD_GRANT;
	endfunction

	// reuse the held window if the slot is unchanged and tail room remains, else start the wait or give unusable
	function verdict_t try_reuse(input logic usable, input logic [63:0] slot);
		int room;
		int used;
		room = int'(regs.slot_length_ms) - int'(regs.post_guard_ms);
		used = int'(win_age) + int'(regs.tail_guard_ms);
		if (win_valid) begin
			if (usable && slot == win_slot && used < room) begin
				ph = PH_IDLE;
				reused_flag = 1'b1;
				return VD_GRANT;
			end
			win_valid = 1'b0;
		end
		if (!usable) begin
			ph = PH_IDLE;
			return VD_UNUSABLE;
		end
		base_slot = slot;
		gate_age = '0;
		ph = PH_WAIT;
		return VD_NONE;
	endfunction

	function verdict_t check_gap(input logic usable, input logic [63:0] slot);
		if (sent_once && since_send < regs.min_gap_ms) begin
			ph = PH_GAP;
			return VD_NONE;
		end
		return try_reuse(usable, slot);
	endfunction

	function verdict_t begin_request(input logic usable, input logic [63:0] slot);
		if (unanswered >= regs.quiet_trigger) begin
			win_valid = 1'b0;
			if (regs.quiet_length_ms == '0) begin
				unanswered = '0;
				return check_gap(usable, slot);
			end
			ph = PH_QUIET;
			phase_timer = regs.quiet_length_ms;
			return VD_NONE;
		end
		return check_gap(usable, slot);
	endfunction

	// one millisecond tick: age counters first, then the active phase
	function verdict_t advance_tick(input logic usable, input logic [63:0] slot);
		if (since_send != 16'hffff)
			since_send++;
		if (win_valid && win_age != 16'hffff)
			win_age++;
		case (ph)
			PH_QUIET: begin
				if (phase_timer != '0)
					phase_timer--;
				if (phase_timer == '0) begin
					unanswered = '0;
					return check_gap(usable, slot);
				end
				return VD_NONE;
			end
			PH_GAP: begin
				return check_gap(usable, slot);
			end
			PH_WAIT: begin
				if (gate_age >= regs.gate_timeout_ms) begin
					ph = PH_IDLE;
					return VD_TIMEOUT;
				end
				if (gate_age != GATE_AGE_MAX)
					gate_age++;
				if (!usable) begin
					ph = PH_IDLE;
					return VD_UNUSABLE;
				end
				if (slot != base_slot) begin
					cand_slot = slot;
					if (regs.post_guard_ms == '0)
						return open_new_window();
					ph = PH_GUARD;
					phase_timer = 14'(regs.post_guard_ms);
				end
				return VD_NONE;
			end
			PH_GUARD: begin
				if (gate_age != GATE_AGE_MAX)
					gate_age++;
				if (phase_timer != '0)
					phase_timer--;
				if (phase_timer == '0) begin
					if (usable && slot == cand_slot)
						return open_new_window();
					ph = PH_WAIT;
				end
				return VD_NONE;
			end
			default: begin
				return VD_NONE;
			end
		endcase
	endfunction

	// expected result of one input transaction
	function res_t gate_step(input logic [IN_DATA_W-1:0] d, input logic [1:0] u);
		item_t    it;
		res_t     r;
		logic     usable;
		verdict_t v;
		it.cmd = cmd_t'(u);
		it.hop_enabled = d[0];
		it.hop_synced = d[1];
		it.role_is_master = d[2];
		it.status_generation = d[34:3];
		it.error_present = d[35];
		it.current_slot = d[99:36];
		it.send_ok = d[100];
		usable = it.hop_enabled && it.hop_synced && it.role_is_master &&
			it.status_generation == regs.expected_generation && !it.error_present;
		reused_flag = 1'b0;
		v = VD_NONE;
		case (it.cmd)
			CMD_TICK: begin
				v = advance_tick(usable, it.current_slot);
			end
			CMD_REQ: begin
				if (ph == PH_IDLE)
					v = begin_request(usable, it.current_slot);
			end
			CMD_DONE: begin
				if (it.send_ok) begin
					sent_once = 1'b1;
					since_send = '0;
					if (unanswered != UNANS_MAX)
						unanswered++;
				end else begin
					win_valid = 1'b0;
				end
			end
			default: begin
				unanswered = '0;
			end
		endcase
		r.verdict = v;
		r.request_busy = (ph != PH_IDLE);
		r.quiet_active = (ph == PH_QUIET);
		r.window_open = win_valid;
		r.window_slot_out = win_valid ? win_slot : '0;
		r.window_reused = (v == VD_GRANT) && reused_flag;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.expected_generation = RST_EXP_GEN;
			regs.slot_length_ms = RST_SLOT_LEN;
			regs.min_gap_ms = RST_MIN_GAP;
			regs.post_guard_ms = RST_POST_GUARD;
			regs.tail_guard_ms = RST_TAIL_GUARD;
			regs.gate_timeout_ms = RST_TIMEOUT;
			regs.quiet_trigger = RST_QUIET_TRIG;
			regs.quiet_length_ms = RST_QUIET_LEN;
			ph = PH_IDLE;
			unanswered = '0;
			sent_once = 1'b0;
			since_send = '0;
			win_valid = 1'b0;
			win_slot = '0;
			win_age = '0;
			base_slot = '0;
			cand_slot = '0;
			phase_timer = '0;
			gate_age = '0;
			reused_flag = 1'b0;
			pending_results.delete();
			in_flight = 0;
		end else begin
			// result transaction against the oldest prediction
			if (m_tvalid && m_tready) begin
				seen.verdict = verdict_t'(m_tdata[1:0]);
				seen.request_busy = m_tdata[2];
				seen.quiet_active = m_tdata[3];
				seen.window_open = m_tdata[4];
				seen.window_slot_out = m_tdata[68:5];
				seen.window_reused = m_tdata[69];
				if (pending_results.size() == 0) begin
					$error("result transaction with no prediction waiting");
					fail_count++;
				end else begin
					oldest = pending_results.pop_front();
					if (seen.verdict !== oldest.verdict) begin
						$error("verdict: expected %0d, got %0d", oldest.verdict, seen.verdict);
						fail_count++;
					end
					if (seen.request_busy !== oldest.request_busy) begin
						$error("request_busy: expected %0d, got %0d",
							oldest.request_busy, seen.request_busy);
						fail_count++;
					end
					if (seen.quiet_active !== oldest.quiet_active) begin
						$error("quiet_active: expected %0d, got %0d",
							oldest.quiet_active, seen.quiet_active);
						fail_count++;
					end
					if (seen.window_open !== oldest.window_open) begin
						$error("window_open: expected %0d, got %0d",
							oldest.window_open, seen.window_open);
						fail_count++;
					end
					if (seen.window_slot_out !== oldest.window_slot_out) begin
						$error("window_slot_out: expected %h, got %h",
							oldest.window_slot_out, seen.window_slot_out);
						fail_count++;
					end
					if (seen.window_reused !== oldest.window_reused) begin
						$error("window_reused: expected %0d, got %0d",
							oldest.window_reused, seen.window_reused);
						fail_count++;
					end
				end
			end
			// register write transaction
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_EXP_GEN:    regs.expected_generation = cfg_data;
					REG_SLOT_LEN:   regs.slot_length_ms = cfg_data[15:0];
					REG_MIN_GAP:    regs.min_gap_ms = cfg_data[9:0];
					REG_POST_GUARD: regs.post_guard_ms = cfg_data[7:0];
					REG_TAIL_GUARD: regs.tail_guard_ms = cfg_data[7:0];
					REG_TIMEOUT:    regs.gate_timeout_ms = cfg_data[11:0];
					REG_QUIET_TRIG: regs.quiet_trigger = cfg_data[3:0];
					REG_QUIET_LEN:  regs.quiet_length_ms = cfg_data[13:0];
					default: ;
				endcase
			end
			// input transaction
			if (s_tvalid && s_tready)
				pending_results.push_back(gate_step(s_tdata, s_tuser));
			in_flight = pending_results.size();
		end
	end

endmodule

FILE: tb/sv/tb_fhss_slot_tx_gate.sv
// top of the slot transmit gate testbench: clock, reset, register phases, item stimulus
// from a simple hop schedule model plus noise, and the final verdict
// depends on fst_pkg, fhss_slot_tx_gate and fst_gate_checker
`timescale 1ns / 100ps

module tb_fhss_slot_tx_gate
	import fst_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned HOLD_AFTER   = 250;
	localparam int unsigned CALM_FROM    = 800;
	localparam int unsigned CALM_TO      = 1300;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           fail_count;
	int unsigned           in_flight;

	int unsigned cycle_count = 0;
	int unsigned results_seen = 0;
	logic        calm;

	// hop schedule seen by the stimulus
	logic [63:0] world_slot;
	logic [31:0] cur_gen;
	int unsigned world_period;
	int unsigned world_ticks;

	fhss_slot_tx_gate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fst_gate_checker gate_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.in_flight  (in_flight)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk)
		if (m_tvalid && m_tready)
			results_seen <= results_seen + 1;

	// result sink: random stalls, one long hold-off so the gate backs up
	initial begin
		int unsigned hold_left;
		bit          hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= 32);
			end
		end
	end

	function automatic item_t build_item(input cmd_t c, input logic en, input logic sync,
		input logic master, input logic [31:0] gen, input logic err,
		input logic [63:0] slot, input logic ok);
		item_t it;
		it.cmd = c;
		it.hop_enabled = en;
		it.hop_synced = sync;
		it.role_is_master = master;
		it.status_generation = gen;
		it.error_present = err;
		it.current_slot = slot;
		it.send_ok = ok;
		return it;
	endfunction

	function automatic cfg_t make_cfg(input logic [31:0] gen, input logic [15:0] slot_len,
		input logic [9:0] gap, input logic [7:0] post, input logic [7:0] tail,
		input logic [11:0] tout, input logic [3:0] qtrig, input logic [13:0] qlen);
		cfg_t c;
		c.expected_generation = gen;
		c.slot_length_ms = slot_len;
		c.min_gap_ms = gap;
		c.post_guard_ms = post;
		c.tail_guard_ms = tail;
		c.gate_timeout_ms = tout;
		c.quiet_trigger = qtrig;
		c.quiet_length_ms = qlen;
		return c;
	endfunction

	// offer one input transaction, with random gaps before it
	task automatic offer(input item_t it);
		while (!calm && $urandom_range(0, 99) < 32) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {3'b000, it.send_ok, it.current_slot, it.error_present,
			it.status_generation, it.role_is_master, it.hop_synced, it.hop_enabled};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// mostly well-formed traffic on a stepping slot schedule, with some noise
	task automatic draw_item(output item_t it);
		int unsigned pick;
		int unsigned spoil;
		cmd_t        c;
		pick = $urandom_range(0, 99);
		if (pick >= 92) begin
			it = build_item(cmd_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
				1'($urandom), ($urandom_range(0, 1) != 0) ? cur_gen : $urandom,
				1'($urandom), {$urandom, $urandom}, 1'($urandom));
		end else begin
			if (pick < 58) begin
				c = CMD_TICK;
				world_ticks++;
				if (world_ticks >= world_period) begin
					world_ticks = 0;
					world_slot++;
				end
			end else if (pick < 74) begin
				c = CMD_REQ;
			end else if (pick < 86) begin
				c = CMD_DONE;
			end else begin
				c = CMD_RX;
			end
			it = build_item(c, 1'b1, 1'b1, 1'b1, cur_gen, 1'b0, world_slot,
				$urandom_range(0, 9) < 8);
			spoil = $urandom_range(0, 29);
			case (spoil)
				0: it.hop_enabled = 1'b0;
				1: it.hop_synced = 1'b0;
				2: it.role_is_master = 1'b0;
				3: it.status_generation = cur_gen ^ (32'd1 << $urandom_range(0, 31));
				4: it.error_present = 1'b1;
				default: ;
			endcase
		end
	endtask

	// wait for the gate to drain, program all registers, then run random items
	task automatic run_phase(input cfg_t c, input int unsigned period,
		input int unsigned count, input logic [63:0] start_slot);
		item_t it;
		s_tvalid <= 1'b0;
		do @(negedge clk); while (in_flight != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		write_reg(REG_EXP_GEN, c.expected_generation);
		write_reg(REG_SLOT_LEN, 32'(c.slot_length_ms));
		write_reg(REG_MIN_GAP, 32'(c.min_gap_ms));
		write_reg(REG_POST_GUARD, 32'(c.post_guard_ms));
		write_reg(REG_TAIL_GUARD, 32'(c.tail_guard_ms));
		write_reg(REG_TIMEOUT, 32'(c.gate_timeout_ms));
		write_reg(REG_QUIET_TRIG, 32'(c.quiet_trigger));
		write_reg(REG_QUIET_LEN, 32'(c.quiet_length_ms));
		cfg_valid <= 1'b0;
		cur_gen = c.expected_generation;
		world_period = period;
		world_ticks = 0;
		world_slot = start_slot;
		repeat (count) begin
			draw_item(it);
			offer(it);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_TICK;
		cfg_valid = 1'b0;
		cfg_index = REG_EXP_GEN;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part on reset defaults
		offer(build_item(CMD_TICK, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 64'd0, 1'b0));
		offer(build_item(CMD_REQ, 1'b0, 1'b1, 1'b1, 32'd0, 1'b0, 64'd5, 1'b0));
		offer(build_item(CMD_REQ, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 64'd5, 1'b0));
		offer(build_item(CMD_REQ, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 64'd5, 1'b1));
		offer(build_item(CMD_TICK, 1'b1, 1'b0, 1'b1, 32'd0, 1'b0, 64'd5, 1'b0));
		offer(build_item(CMD_REQ, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 64'd7, 1'b0));
		offer(build_item(CMD_TICK, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 64'd7, 1'b0));
		offer(build_item(CMD_TICK, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 64'd8, 1'b0));
		offer(build_item(CMD_DONE, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 64'd8, 1'b1));
		offer(build_item(CMD_DONE, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 64'd8, 1'b0));
		offer(build_item(CMD_RX, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 64'd8, 1'b0));
		offer(build_item(CMD_TICK, 1'b1, 1'b1, 1'b1, 32'hffff_ffff, 1'b1,
			64'hffff_ffff_ffff_ffff, 1'b1));
		offer(build_item(CMD_RX, 1'b1, 1'b1, 1'b1, 32'hffff_ffff, 1'b1,
			64'hffff_ffff_ffff_ffff, 1'b1));
		offer(build_item(CMD_DONE, 1'b1, 1'b1, 1'b1, 32'hffff_ffff, 1'b1,
			64'hffff_ffff_ffff_ffff, 1'b1));
		offer(build_item(CMD_TICK, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 64'd8, 1'b0));

		// short slots with reuse, quiet pauses and guards
		run_phase(make_cfg($urandom, 16'd8, 10'd3, 8'd2, 8'd1, 12'd20, 4'd3, 14'd6),
			8, 240, {$urandom, $urandom});
		// zero post guard, zero quiet trigger and zero quiet length
		run_phase(make_cfg(32'hffff_ffff, 16'd5, 10'd0, 8'd0, 8'd0, 12'd12, 4'd0, 14'd0),
			4, 120, {$urandom, $urandom});
		// zero slot length never has room, zero timeout fails at once
		run_phase(make_cfg(32'd0, 16'd0, 10'd1, 8'd1, 8'd255, 12'd0, 4'd15, 14'd2),
			1, 60, {$urandom, $urandom});
		// every length, gap, guard and timeout register at its top value, quiet trigger at one
		run_phase(make_cfg($urandom, 16'hffff, 10'h3ff, 8'hff, 8'hff, 12'hfff, 4'd1,
			14'h3fff), 50, 60, {$urandom, $urandom});
		run_phase(make_cfg($urandom, 16'd12, 10'd2, 8'd3, 8'd2, 12'd30, 4'd4, 14'd0),
			10, 200, {$urandom, $urandom});
		// schedule slower than the timeout, slot numbers wrapping around
		run_phase(make_cfg($urandom, 16'd3, 10'd5, 8'd1, 8'd0, 12'd9, 4'd2, 14'd4),
			15, 150, 64'hffff_ffff_ffff_fffa);

		s_tvalid <= 1'b0;
		do @(negedge clk); while (in_flight != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/fst_pkg.sv
rtl/fst_cfg.sv
rtl/fst_core.sv
rtl/fhss_slot_tx_gate.sv
tb/sv/fst_gate_checker.sv
tb/sv/tb_fhss_slot_tx_gate.sv
